>>> rtl/core/css_pkg.sv
// ----------------------------------------------------------------------------
// Camera source sequencer package
// Shared widths, mode codes and register indexes of the sequencer core.
// ----------------------------------------------------------------------------
package css_pkg;

  // Wait counter width (8 to 32)
  localparam int unsigned CountWidth = 16;
  // Compare width covers both the counter and the 16-bit tick registers
  localparam int unsigned CmpWidth   = (CountWidth > 16) ? CountWidth : 16;

  localparam int unsigned ModeWidth  = 3;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  // Sequencer modes
  localparam logic [ModeWidth-1:0] ModeClear       = 3'd0;
  localparam logic [ModeWidth-1:0] ModeWaitReverse = 3'd1;
  localparam logic [ModeWidth-1:0] ModeRearView    = 3'd2;
  localparam logic [ModeWidth-1:0] ModeWaitRelease = 3'd3;
  localparam logic [ModeWidth-1:0] ModeWaitStop    = 3'd4;
  localparam logic [ModeWidth-1:0] ModeHold        = 3'd5;
  localparam logic [ModeWidth-1:0] ModeFrontView   = 3'd6;
  localparam logic [ModeWidth-1:0] ModeWatch       = 3'd7;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegStopHold   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrontView  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSpeedCut   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0] StopHoldReset  = 16'd2000;
  localparam logic [15:0] FrontViewReset = 16'd6000;
  localparam logic [7:0]  SpeedCutReset  = 8'd6;

endpackage

>>> rtl/core/camera_source_sequencer_core.sv
// ----------------------------------------------------------------------------
// Camera source sequencer core
// Eight-mode rear/front camera sequencer driven by one tick transaction.
// ----------------------------------------------------------------------------
// One tick transaction enters per clock cycle while in_ready_o is high, and
// each yields exactly one result transaction: the tick is captured in an input
// register, and the mode step (edge detect, a saturating counter increment and
// two compares) runs between that register and the result register. The output
// register and the input register form a two-entry pipe, so a tick is still
// accepted while a finished result waits to be taken. Configuration writes
// are always accepted and take effect on the next tick; write them only
// while no tick is in flight. There is no clearing pass after reset.
module camera_source_sequencer_core
  import css_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  // tick input channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   reverse_level_i,
  input  logic [7:0]             vehicle_speed_i,
  input  logic                   kill_request_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   rear_selected_o,
  output logic                   trigger_on_o,
  output logic                   speed_wanted_o,
  output logic                   front_active_o,
  output logic                   send_strobe_o,
  output logic [ModeWidth-1:0]   mode_now_o
);

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  // configuration registers
  logic [15:0] stop_hold_q;
  logic [15:0] front_view_q;
  logic [7:0]  speed_cut_q;

  // input stage
  logic        s1_valid_q;
  logic        s1_rev_q;
  logic [7:0]  s1_speed_q;
  logic        s1_kill_q;

  // sequencer state
  logic [ModeWidth-1:0]  mode_q, mode_d;
  logic                  last_rev_q;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic                  rear_q, rear_d;
  logic                  trig_q, trig_d;
  logic                  sw_q, sw_d;
  logic                  fa_q, fa_d;
  logic                  send_d;

  // result stage
  logic                  out_valid_q;
  logic                  out_rear_q, out_trig_q, out_sw_q, out_fa_q, out_send_q;
  logic [ModeWidth-1:0]  out_mode_q;

  logic                  s2_ready;
  logic                  step;
  logic [ModeWidth-1:0]  mode_eff;
  logic [CountWidth-1:0] cnt_inc;
  logic                  cnt_sat;
  logic                  hold_done;
  logic                  view_done;

  assign cfg_ready_o = 1'b1;
  assign s2_ready    = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || s2_ready;
  assign step        = s1_valid_q && s2_ready;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_hold_q  <= StopHoldReset;
      front_view_q <= FrontViewReset;
      speed_cut_q  <= SpeedCutReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegStopHold:  stop_hold_q  <= cfg_data_i;
        RegFrontView: front_view_q <= cfg_data_i;
        RegSpeedCut:  speed_cut_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // capture the tick transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_rev_q   <= reverse_level_i;
      s1_speed_q <= vehicle_speed_i;
      s1_kill_q  <= kill_request_i;
    end
  end

  // saturating counter increment shared by the hold and watch modes
  assign cnt_sat   = (cnt_q == CountMax);
  assign cnt_inc   = cnt_sat ? cnt_q : cnt_q + 1'b1;
  assign hold_done = (CmpWidth'(cnt_inc) >= CmpWidth'(stop_hold_q)) || (cnt_inc == CountMax);
  assign view_done = (CmpWidth'(cnt_inc) >= CmpWidth'(front_view_q)) || (cnt_inc == CountMax);

  // advance the sequencer by one mode at most
  always_comb begin
    mode_eff = (s1_rev_q && !last_rev_q) ? ModeWaitReverse : mode_q;
    mode_d   = mode_eff;
    cnt_d    = cnt_q;
    rear_d   = rear_q;
    trig_d   = trig_q;
    sw_d     = sw_q;
    fa_d     = fa_q;
    send_d   = 1'b0;
    case (mode_eff)
      ModeClear: begin
        rear_d = 1'b0;
        trig_d = 1'b0;
        sw_d   = 1'b0;
        fa_d   = 1'b0;
        send_d = 1'b1;
        mode_d = ModeWaitReverse;
      end
      ModeWaitReverse: begin
        if (s1_rev_q) mode_d = ModeRearView;
      end
      ModeRearView: begin
        rear_d = 1'b1;
        trig_d = 1'b1;
        sw_d   = 1'b1;
        send_d = 1'b1;
        mode_d = ModeWaitRelease;
      end
      ModeWaitRelease: begin
        if (!s1_rev_q) mode_d = ModeWaitStop;
      end
      ModeWaitStop: begin
        if (s1_speed_q == 8'd0) begin
          cnt_d  = '0;
          mode_d = ModeHold;
        end
      end
      ModeHold: begin
        cnt_d = cnt_inc;
        if (hold_done) mode_d = ModeFrontView;
      end
      ModeFrontView: begin
        rear_d = 1'b0;
        fa_d   = 1'b1;
        send_d = 1'b1;
        cnt_d  = '0;
        mode_d = ModeWatch;
      end
      default: begin
        cnt_d = cnt_inc;
        if (view_done || (s1_speed_q >= speed_cut_q) || s1_kill_q) mode_d = ModeClear;
      end
    endcase
  end

  // update sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeWaitReverse;
      last_rev_q <= 1'b0;
      cnt_q      <= '0;
      rear_q     <= 1'b0;
      trig_q     <= 1'b0;
      sw_q       <= 1'b0;
      fa_q       <= 1'b0;
    end else if (step) begin
      mode_q     <= mode_d;
      last_rev_q <= s1_rev_q;
      cnt_q      <= cnt_d;
      rear_q     <= rear_d;
      trig_q     <= trig_d;
      sw_q       <= sw_d;
      fa_q       <= fa_d;
    end
  end

  // hold the result transaction until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_rear_q <= rear_d;
      out_trig_q <= trig_d;
      out_sw_q   <= sw_d;
      out_fa_q   <= fa_d;
      out_send_q <= send_d;
      out_mode_q <= mode_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign rear_selected_o = out_rear_q;
  assign trigger_on_o    = out_trig_q;
  assign speed_wanted_o  = out_sw_q;
  assign front_active_o  = out_fa_q;
  assign send_strobe_o   = out_send_q;
  assign mode_now_o      = out_mode_q;

  // a send only leaves the clear, rear view or front view modes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_send_q |->
      (out_mode_q == ModeWaitReverse) || (out_mode_q == ModeWaitRelease) ||
      (out_mode_q == ModeWatch))
    else $error("send strobe with unexpected next mode");

  // the speed request flag follows the trigger
  assert property (@(posedge clk_i) disable iff (!rst_ni) sw_q == trig_q)
    else $error("speed wanted and trigger differ");

  // front view is only reached through rear view, so trigger is on
  assert property (@(posedge clk_i) disable iff (!rst_ni) fa_q |-> trig_q)
    else $error("front active without trigger");

  // input stalls only under output back pressure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_q && !out_ready_i)
    else $error("input stalled without output back pressure");

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Camera source sequencer core testbench
// Drives millisecond tick transactions and configuration writes into the
// sequencer core, predicts every result transaction with a cycle-free model
// of the eight-mode sequencer, and compares each result field by field.
// Stimulus: a directed opening, one long hold with no idling, then random
// phases of complete reverse/stop/front-view drives mixed with noise.
// ----------------------------------------------------------------------------
import css_pkg::*;

typedef struct packed {
  logic                 rear;
  logic                 trig;
  logic                 spd_req;
  logic                 front;
  logic                 send;
  logic [ModeWidth-1:0] mode;
} cam_view_t;

// Predicts the camera outputs of each tick and holds them until they arrive
class view_scoreboard;
  logic [15:0]           stop_hold;
  logic [15:0]           front_view;
  logic [7:0]            cutoff;
  logic [ModeWidth-1:0]  mode;
  logic                  last_rev;
  logic [CountWidth-1:0] wait_cnt;
  logic                  rear, trig, spd_req, front;
  cam_view_t             views_due[$];
  int unsigned           errors;

  function new();
    stop_hold  = StopHoldReset;
    front_view = FrontViewReset;
    cutoff     = SpeedCutReset;
    mode       = ModeWaitReverse;
    last_rev   = 1'b0;
    wait_cnt   = '0;
    rear       = 1'b0;
    trig       = 1'b0;
    spd_req    = 1'b0;
    front      = 1'b0;
    errors     = 0;
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      RegStopHold:  stop_hold  = data;
      RegFrontView: front_view = data;
      RegSpeedCut:  cutoff     = data[7:0];
      default: ;
    endcase
  endfunction

  // Advance the saturating counter; a full counter always counts as elapsed
  function bit count_up(logic [15:0] limit);
    if (wait_cnt != '1) wait_cnt = wait_cnt + 1'b1;
    return (wait_cnt >= limit) || (wait_cnt == '1);
  endfunction

  // Step the sequencer by one accepted tick and queue the expected view
  function void note_tick(logic rev, logic [7:0] spd, logic kil);
    cam_view_t v;
    bit        done;
    v.send = 1'b0;
    if (rev && !last_rev) mode = ModeWaitReverse;
    last_rev = rev;
    case (mode)
      ModeClear: begin
        trig    = 1'b0;
        rear    = 1'b0;
        front   = 1'b0;
        spd_req = 1'b0;
        v.send  = 1'b1;
        mode    = ModeWaitReverse;
      end
      ModeWaitReverse: begin
        if (rev) mode = ModeRearView;
      end
      ModeRearView: begin
        rear    = 1'b1;
        trig    = 1'b1;
        spd_req = 1'b1;
        v.send  = 1'b1;
        mode    = ModeWaitRelease;
      end
      ModeWaitRelease: begin
        if (!rev) mode = ModeWaitStop;
      end
      ModeWaitStop: begin
        if (spd == 8'd0) begin
          wait_cnt = '0;
          mode     = ModeHold;
        end
      end
      ModeHold: begin
        if (count_up(stop_hold)) mode = ModeFrontView;
      end
      ModeFrontView: begin
        rear     = 1'b0;
        front    = 1'b1;
        v.send   = 1'b1;
        wait_cnt = '0;
        mode     = ModeWatch;
      end
      default: begin
        done = count_up(front_view);
        if (done || spd >= cutoff || kil) mode = ModeClear;
      end
    endcase
    v.rear    = rear;
    v.trig    = trig;
    v.spd_req = spd_req;
    v.front   = front;
    v.mode    = mode;
    views_due.push_back(v);
  endfunction

  function int unsigned pending();
    return views_due.size();
  endfunction

  // Compare one result transaction with the oldest expected view
  function void check_view(cam_view_t got);
    cam_view_t want;
    if (views_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: rear=%0b trig=%0b spd=%0b front=%0b send=%0b mode=%0d",
                 got.rear, got.trig, got.spd_req, got.front, got.send, got.mode);
      return;
    end
    want = views_due.pop_front();
    if (got.rear !== want.rear || got.trig !== want.trig || got.spd_req !== want.spd_req ||
        got.front !== want.front || got.send !== want.send || got.mode !== want.mode) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: want rear=%0b trig=%0b spd=%0b front=%0b send=%0b mode=%0d, %s",
                 want.rear, want.trig, want.spd_req, want.front, want.send, want.mode,
                 $sformatf("got rear=%0b trig=%0b spd=%0b front=%0b send=%0b mode=%0d",
                           got.rear, got.trig, got.spd_req, got.front, got.send, got.mode));
    end
  endfunction
endclass

module testbench;
  import css_pkg::*;

  localparam int unsigned        WatchdogLimit = 2000;
  localparam int unsigned        HoldOffCycles = 64;
  localparam int unsigned        HoldCap       = 60;
  localparam int unsigned        RandomTicks   = 1200;
  localparam logic [CfgIdxW-1:0] RegUnused     = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 reverse_level_i;
  logic [7:0]           vehicle_speed_i;
  logic                 kill_request_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 rear_selected_o;
  logic                 trigger_on_o;
  logic                 speed_wanted_o;
  logic                 front_active_o;
  logic                 send_strobe_o;
  logic [ModeWidth-1:0] mode_now_o;

  view_scoreboard sb;
  bit             idle_en;
  bit             hold_req;
  bit             tick_offered;
  int unsigned    ticks_sent;
  int unsigned    quiet_cycles;
  logic [15:0]    cur_hold;
  logic [15:0]    cur_front;
  logic [7:0]     cur_cut;

  camera_source_sequencer_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .reverse_level_i (reverse_level_i),
    .vehicle_speed_i (vehicle_speed_i),
    .kill_request_i  (kill_request_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .rear_selected_o (rear_selected_o),
    .trigger_on_o    (trigger_on_o),
    .speed_wanted_o  (speed_wanted_o),
    .front_active_o  (front_active_o),
    .send_strobe_o   (send_strobe_o),
    .mode_now_o      (mode_now_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Check every result transaction as it is taken
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_view('{rear: rear_selected_o, trig: trigger_on_o, spd_req: speed_wanted_o,
                      front: front_active_o, send: send_strobe_o, mode: mode_now_o});
  end

  // Drop the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[camera_source_sequencer_core] ERROR");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= !(idle_en && $urandom_range(99) < 25);
      end
    end
  end

  // Offer one tick, wait until it is accepted, then maybe idle a while
  task automatic send_tick(input logic rev, input logic [7:0] spd, input logic kil);
    int unsigned gap;
    in_valid_i      <= 1'b1;
    reverse_level_i <= rev;
    vehicle_speed_i <= spd;
    kill_request_i  <= kil;
    tick_offered    = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_tick(rev, spd, kil);
    ticks_sent++;
    @(negedge clk_i);
    gap = 0;
    while (idle_en && $urandom_range(99) < 25) gap++;
    if (gap != 0) begin
      in_valid_i   <= 1'b0;
      tick_offered = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Stop offering ticks and wait until every expected result has come
  task automatic flush_ticks();
    if (tick_offered) begin
      in_valid_i   <= 1'b0;
      tick_offered = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One register write; the caller lowers valid after the last one
  task automatic cfg_put(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic write_config(input logic [15:0] hold, input logic [15:0] front,
                              input logic [15:0] cut_data, input bit poke_unused);
    cfg_put(RegStopHold, hold);
    cfg_put(RegFrontView, front);
    cfg_put(RegSpeedCut, cut_data);
    if (poke_unused) cfg_put(RegUnused, 16'h5AC3);
    cfg_valid_i <= 1'b0;
    cur_hold  = hold;
    cur_front = front;
    cur_cut   = cut_data[7:0];
  endtask

  // One drive: reverse, release, roll, stop, hold, front view, watch; or a hold aborted by a fresh reverse edge
  task automatic run_drive(input int unsigned cap);
    int unsigned n;
    int unsigned i;
    logic [7:0]  spd;
    logic        kil;
    bit          ending;
    repeat ($urandom_range(1, 3))
      send_tick(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)));
    repeat ($urandom_range(1, 5))
      send_tick(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
    repeat ($urandom_range(0, 4))
      send_tick(1'b0, 8'($urandom_range(1, 255)), 1'($urandom_range(1)));
    // stop, then count out the hold
    send_tick(1'b0, 8'd0, 1'($urandom_range(1)));
    n = (cur_hold == 0) ? 1 : cur_hold;
    if (n > cap || $urandom_range(99) < 8) begin
      // abort the hold with a fresh reverse edge
      repeat ($urandom_range(0, (n > cap) ? cap : n - 1))
        send_tick(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)));
      send_tick(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
      return;
    end
    repeat (n) send_tick(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)));
    send_tick(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)));
    // watch the front view until timeout, speed or kill
    n = cur_front + $urandom_range(0, 3);
    if (n > cap) n = cap;
    for (i = 0; i < n; i++) begin
      ending = ($urandom_range(99) < 5);
      if (ending) begin
        kil = 1'($urandom_range(1));
        spd = kil ? 8'($urandom_range(255)) : 8'($urandom_range(cur_cut, 255));
      end else begin
        kil = ($urandom_range(99) < 3);
        spd = (cur_cut != 0) ? 8'($urandom_range(0, cur_cut - 1)) : 8'($urandom_range(255));
      end
      send_tick(1'b0, spd, kil);
      if (ending) break;
    end
    repeat ($urandom_range(1, 2))
      send_tick(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  initial begin
    int unsigned base;
    int unsigned phase;
    int unsigned kind;
    sb              = new();
    idle_en         = 1'b1;
    hold_req        = 1'b0;
    tick_offered    = 1'b0;
    ticks_sent      = 0;
    quiet_cycles    = 0;
    cur_hold        = StopHoldReset;
    cur_front       = FrontViewReset;
    cur_cut         = SpeedCutReset;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    reverse_level_i = 1'b0;
    vehicle_speed_i = '0;
    kill_request_i  = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero hold and front view limits, full sequence through clear
    write_config(16'd0, 16'd0, 16'hA5FF, 1'b1);
    send_tick(1'b0, 8'd0, 1'b0);
    send_tick(1'b1, 8'd0, 1'b0);
    send_tick(1'b1, 8'd255, 1'b1);
    send_tick(1'b1, 8'd0, 1'b1);
    send_tick(1'b0, 8'd255, 1'b0);
    send_tick(1'b0, 8'd128, 1'b1);
    send_tick(1'b0, 8'd0, 1'b0);
    send_tick(1'b0, 8'd0, 1'b0);
    send_tick(1'b0, 8'd0, 1'b0);
    send_tick(1'b0, 8'd0, 1'b0);
    send_tick(1'b0, 8'd0, 1'b0);
    flush_ticks();

    // Directed: reverse edge during hold, then speed reaching the cutoff
    write_config(16'd1, 16'hFFFF, 16'd200, 1'b0);
    send_tick(1'b1, 8'd0, 1'b0);
    send_tick(1'b1, 8'd0, 1'b0);
    send_tick(1'b0, 8'd9, 1'b0);
    send_tick(1'b0, 8'd0, 1'b0);
    send_tick(1'b1, 8'd0, 1'b0);
    send_tick(1'b1, 8'd0, 1'b0);
    send_tick(1'b0, 8'd0, 1'b0);
    send_tick(1'b0, 8'd0, 1'b0);
    send_tick(1'b0, 8'd77, 1'b0);
    send_tick(1'b0, 8'd0, 1'b0);
    send_tick(1'b0, 8'd199, 1'b0);
    send_tick(1'b0, 8'd200, 1'b0);
    send_tick(1'b0, 8'd0, 1'b0);
    flush_ticks();

    // Long hold and front view, no idling on either side
    idle_en = 1'b0;
    write_config(16'd200, 16'hFFFF, 16'h00FF, 1'b0);
    send_tick(1'b1, 8'd3, 1'b0);
    send_tick(1'b1, 8'd3, 1'b0);
    send_tick(1'b0, 8'd3, 1'b0);
    send_tick(1'b0, 8'd0, 1'b0);
    repeat (200) send_tick(1'b0, 8'($urandom_range(255)), 1'b0);
    send_tick(1'b0, 8'd0, 1'b0);
    repeat (20) send_tick(1'b0, 8'($urandom_range(254)), 1'b0);
    send_tick(1'b0, 8'd0, 1'b1);
    send_tick(1'b0, 8'd0, 1'b0);
    flush_ticks();
    idle_en = 1'b1;

    // Random phases, each under a fresh setting
    base  = ticks_sent;
    phase = 0;
    while (ticks_sent - base < RandomTicks) begin
      flush_ticks();
      kind = $urandom_range(9);
      case (kind)
        0:       write_config(16'd0, 16'd0, {8'($urandom_range(255)), 8'd0}, 1'b0);
        1:       write_config(16'hFFFF, 16'hFFFF, {8'($urandom_range(255)), 8'd255}, 1'b0);
        2:       write_config(16'd0, 16'($urandom_range(8)), 16'h00FF, 1'b0);
        default: write_config(16'($urandom_range(10)), 16'($urandom_range(12)),
                              16'($urandom_range(16'hFFFF)), 1'b0);
      endcase
      idle_en = ($urandom_range(7) != 0);
      // fill the block while the result side holds off
      if (phase == 1 || $urandom_range(7) == 0) hold_req = 1'b1;
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(99) < 85)
          run_drive(HoldCap);
        else
          repeat ($urandom_range(1, 15))
            send_tick(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      phase++;
    end
    flush_ticks();
    repeat (8) @(posedge clk_i);

    if (sb.errors == 0)
      $display("[camera_source_sequencer_core] OK");
    else
      $display("[camera_source_sequencer_core] ERROR");
    $finish;
  end

endmodule
